[src/bilinear_image_resizer_defines.svh]
// Assertion macros for the bilinear image resizer.
// The scope that uses them must declare clk and rst_n.
`ifndef BILINEAR_IMAGE_RESIZER_DEFINES_SVH
`define BILINEAR_IMAGE_RESIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bilinear_image_resizer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BIR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bilinear_image_resizer: next-cycle check failed");

`endif

[src/bir_pkg.sv]
// Shared types and constants of the bilinear image resizer.
// No dependencies; every module of the block and the testbench import this package.
package bir_pkg;

  localparam int COORD_W    = 10;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int RES_W      = 24;
  localparam int CFG_SRC_W  = 9;
  localparam int CFG_OUT_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int NUM_W      = 20;  // holds (2o+1)*S
  localparam int DEN_W      = 12;  // holds 2*O
  localparam int CMP_W      = 13;  // compare width for positions against sizes
  localparam int NUM_TAPS   = 4;
  localparam int STEP_W     = 2;
  localparam int OQ_DEPTH   = 2;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

  localparam logic [CFG_SRC_W-1:0] SRC_SIZE_RST = 9'd256;
  localparam logic [CFG_OUT_W-1:0] OUT_SIZE_RST = 11'd256;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [STEP_W-1:0] STEP_LAST = 2'd3;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SAMPLE,
    KIND_RANGE
  } kind_t;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic [CHAN_W-1:0]  chan_blue;
    logic [CHAN_W-1:0]  chan_green;
    logic [CHAN_W-1:0]  chan_red;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] out_blue;
    logic [RES_W-1:0] out_green;
    logic [RES_W-1:0] out_red;
    logic             status;
  } out_t;

  // Transaction kind and coordinates that travel beside the axis lanes.
  typedef struct packed {
    logic               v;
    kind_t              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   rgb;
  } side_t;

  typedef struct packed {
    logic  v;
    kind_t kind;
  } job_ctl_t;

endpackage

[src/bir_axis_lane.sv]
// One axis lane: maps an output coordinate to a clamped source position and fraction.
// Pipelined restoring divider, one quotient bit per stage. Depends on bir_pkg.
module bir_axis_lane #(
  parameter int INT_W  = 8,
  parameter int POS_W  = 8,
  parameter int FRAC_W = 8
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [bir_pkg::COORD_W-1:0]  coord,
  input  logic [bir_pkg::CFG_SRC_W-1:0] src_size,
  input  logic [bir_pkg::CFG_OUT_W-1:0] out_size,
  output logic [POS_W-1:0]             pos_lo,
  output logic [POS_W-1:0]             pos_hi,
  output logic [FRAC_W-1:0]            pos_frac
);
  import bir_pkg::*;

  localparam int QW = INT_W + FRAC_W;
  localparam int NW = NUM_W + FRAC_W;

  logic [NUM_W-1:0] prod;
  logic [NUM_W-1:0] num;
  logic             num_pos;
  logic [NW-1:0]    dividend;
  logic [DEN_W-1:0] den;

  logic [DEN_W-1:0] rem_r [QW+1];
  logic [QW-1:0]    ql_r  [QW+1];

  logic [INT_W-1:0]  q_int;
  logic [CMP_W-1:0]  q_ext;
  logic [CMP_W-1:0]  size_ext;
  logic [CMP_W-1:0]  size_m1;
  logic [CMP_W-1:0]  lo_nxt;
  logic [CMP_W-1:0]  lo_inc;
  logic [CMP_W-1:0]  hi_nxt;
  logic [FRAC_W-1:0] frac_nxt;
  logic [POS_W-1:0]  lo_r;
  logic [POS_W-1:0]  hi_r;
  logic [FRAC_W-1:0] frac_r;

  // Numerator (2o+1)*S - O scaled by the fraction bits; zero when not positive.
  always_comb begin
    prod     = NUM_W'({coord, 1'b1}) * NUM_W'(src_size);
    num_pos  = prod > NUM_W'(out_size);
    num      = prod - NUM_W'(out_size);
    dividend = num_pos ? (NW'(num) << FRAC_W) : '0;
    den      = {out_size, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // The quotient is below S * 2^FRAC_W, so the upper part is below den.
      rem_r[0] <= DEN_W'(dividend >> QW);
      ql_r[0]  <= dividend[QW-1:0];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DEN_W:0] trial;
    logic           take;

    always_comb begin
      trial = {rem_r[k], ql_r[k][QW-1]};
      take  = trial >= {1'b0, den};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        ql_r[k+1]  <= {ql_r[k][QW-2:0], take};
      end
    end
  end

  // A position at or past the last column pins both neighbors to the edge.
  always_comb begin
    q_int    = ql_r[QW][QW-1:FRAC_W];
    q_ext    = CMP_W'(q_int);
    size_ext = CMP_W'(src_size);
    size_m1  = size_ext - CMP_W'(1);
    if (q_ext >= size_m1) begin
      lo_nxt   = size_m1;
      frac_nxt = '0;
    end else begin
      lo_nxt   = q_ext;
      frac_nxt = ql_r[QW][FRAC_W-1:0];
    end
    lo_inc = lo_nxt + CMP_W'(1);
    hi_nxt = (lo_inc < size_ext) ? lo_inc : size_m1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r   <= POS_W'(lo_nxt);
      hi_r   <= POS_W'(hi_nxt);
      frac_r <= frac_nxt;
    end
  end

  assign pos_lo   = lo_r;
  assign pos_hi   = hi_r;
  assign pos_frac = frac_r;

endmodule

[src/bir_sampler.sv]
// Merging stage: combines the two axis lanes into four tap addresses and bilinear weights.
// Also forms the store address of pixel writes. Depends on bir_pkg.
module bir_sampler #(
  parameter int POS_X_W   = 8,
  parameter int POS_Y_W   = 8,
  parameter int FRAC_W    = 8,
  parameter int ADDR_W    = 16,
  parameter int ROW_PITCH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  bir_pkg::side_t                side,
  input  logic [POS_X_W-1:0]            x_lo,
  input  logic [POS_X_W-1:0]            x_hi,
  input  logic [FRAC_W-1:0]             x_frac,
  input  logic [POS_Y_W-1:0]            y_lo,
  input  logic [POS_Y_W-1:0]            y_hi,
  input  logic [FRAC_W-1:0]             y_frac,
  output bir_pkg::job_ctl_t             job_ctl,
  output logic [3:0][ADDR_W-1:0]        job_addr,
  output logic [3:0][2*FRAC_W:0]        job_w,
  output logic [bir_pkg::PIX_W-1:0]     job_rgb
);
  import bir_pkg::*;

  localparam int WW = 2 * FRAC_W + 1;
  localparam int PP = 2 * FRAC_W + 2;

  logic [FRAC_W:0]        one;
  logic [FRAC_W:0]        wx0;
  logic [FRAC_W:0]        wx1;
  logic [FRAC_W:0]        wy0;
  logic [FRAC_W:0]        wy1;
  logic [ADDR_W-1:0]      row0;
  logic [ADDR_W-1:0]      row1;
  logic [ADDR_W-1:0]      col0;
  logic [ADDR_W-1:0]      col1;
  logic [ADDR_W-1:0]      base0;
  logic [ADDR_W-1:0]      base1;
  logic [3:0][ADDR_W-1:0] addr_nxt;
  logic [3:0][WW-1:0]     w_nxt;

  job_ctl_t               ctl_r;
  logic [3:0][ADDR_W-1:0] addr_r;
  logic [3:0][WW-1:0]     w_r;
  logic [PIX_W-1:0]       rgb_r;

  always_comb begin
    one = {1'b1, FRAC_W'(0)};
    wx1 = {1'b0, x_frac};
    wy1 = {1'b0, y_frac};
    wx0 = one - wx1;
    wy0 = one - wy1;
    w_nxt[0] = WW'(PP'(wy0) * PP'(wx0));
    w_nxt[1] = WW'(PP'(wy0) * PP'(wx1));
    w_nxt[2] = WW'(PP'(wy1) * PP'(wx0));
    w_nxt[3] = WW'(PP'(wy1) * PP'(wx1));

    // A write uses the first tap for its own store address.
    if (side.kind == KIND_WRITE) begin
      row0 = ADDR_W'(side.y);
      col0 = ADDR_W'(side.x);
    end else begin
      row0 = ADDR_W'(y_lo);
      col0 = ADDR_W'(x_lo);
    end
    row1  = ADDR_W'(y_hi);
    col1  = ADDR_W'(x_hi);
    base0 = row0 * ADDR_W'(ROW_PITCH);
    base1 = row1 * ADDR_W'(ROW_PITCH);
    addr_nxt[0] = base0 + col0;
    addr_nxt[1] = base0 + col1;
    addr_nxt[2] = base1 + col0;
    addr_nxt[3] = base1 + col1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.v <= 1'b0;
    end else if (adv) begin
      ctl_r.v <= side.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r.kind <= side.kind;
      addr_r     <= addr_nxt;
      w_r        <= w_nxt;
      rgb_r      <= side.rgb;
    end
  end

  assign job_ctl  = ctl_r;
  assign job_addr = addr_r;
  assign job_w    = w_r;
  assign job_rgb  = rgb_r;

endmodule

[src/bir_fetch.sv]
// Fetch and accumulate unit: frame memory, four-tap read sequencer, per-channel MAC
// and a two-entry result queue. Depends on bir_pkg.
module bir_fetch #(
  parameter int DEPTH  = 65536,
  parameter int FRAC_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bir_pkg::job_ctl_t         job_ctl,
  input  logic [3:0][ADDR_W-1:0]    job_addr,
  input  logic [3:0][2*FRAC_W:0]    job_w,
  input  logic [bir_pkg::PIX_W-1:0] job_rgb,
  output logic                      job_done,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bir_pkg::out_t             out_payload
);
  import bir_pkg::*;

  localparam int WW    = 2 * FRAC_W + 1;
  localparam int PW    = 2 * FRAC_W + 8;
  localparam int EXT_W = PW + 16;

  logic [PIX_W-1:0] frame_mem_r [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  logic is_write;
  logic is_sample;
  logic is_range;
  logic room;
  logic go;
  logic last_step;
  logic start;
  logic push;
  logic pop;

  logic [STEP_W-1:0]   step_r;
  logic [STEP_W-1:0]   step_nxt;
  logic [OQ_CNT_W-1:0] resv_r;
  logic [OQ_CNT_W-1:0] resv_nxt;

  logic          t1_v_r;
  logic          t1_first_r;
  logic          t1_last_r;
  logic          t1_err_r;
  logic [WW-1:0] t1_w_r;

  logic               t2_v_r;
  logic               t2_first_r;
  logic               t2_last_r;
  logic               t2_err_r;
  logic [2:0][PW-1:0] prod_r;
  logic [2:0][PW-1:0] prod_nxt;
  logic [2:0][PW-1:0] acc_r;
  logic [2:0][PW-1:0] sum;
  logic [2:0][EXT_W-1:0] ext;
  logic [2:0][RES_W-1:0] res;
  out_t                  entry;

  out_t                q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r;
  logic [OQ_PTR_W-1:0] rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;

  // Sequencer: a write is a single memory write, a sample four reads; a sample or range error
  // starts only when a queue slot is reserved for its result.
  always_comb begin
    is_write  = job_ctl.kind == KIND_WRITE;
    is_sample = job_ctl.kind == KIND_SAMPLE;
    is_range  = job_ctl.kind == KIND_RANGE;
    room      = resv_r < OQ_CNT_W'(OQ_DEPTH);
    go        = job_ctl.v && (is_write || step_r != '0 || room);
    last_step = !is_sample || step_r == STEP_LAST;
    job_done  = go && last_step;
    start     = go && !is_write && step_r == '0;
    pop       = out_valid && out_ready;
    push      = t2_v_r && t2_last_r;
    step_nxt  = step_r;
    if (go && is_sample) begin
      step_nxt = last_step ? '0 : step_r + STEP_W'(1);
    end
    resv_nxt = resv_r + OQ_CNT_W'(start) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (go && is_write) begin
      frame_mem_r[job_addr[0]] <= job_rgb;
    end
    if (go && !is_write) begin
      rd_data_r <= frame_mem_r[job_addr[step_r]];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c] = t1_err_r ? '0
                  : PW'(t1_w_r) * PW'(rd_data_r[c*CHAN_W +: CHAN_W]);
      sum[c] = (t2_first_r ? '0 : acc_r[c]) + prod_r[c];
      ext[c] = EXT_W'(sum[c]) << 16;
      res[c] = RES_W'(ext[c] >> (2 * FRAC_W));
    end
    entry.out_blue  = res[0];
    entry.out_green = res[1];
    entry.out_red   = res[2];
    entry.status    = t2_err_r ? STATUS_RANGE : STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      resv_r   <= '0;
      t1_v_r   <= 1'b0;
      t2_v_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      step_r <= step_nxt;
      resv_r <= resv_nxt;
      t1_v_r <= go && !is_write;
      t2_v_r <= t1_v_r;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      end
      cnt_r <= cnt_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    t1_first_r <= step_r == '0;
    t1_last_r  <= last_step;
    t1_err_r   <= is_range;
    t1_w_r     <= job_w[step_r];
    t2_first_r <= t1_first_r;
    t2_last_r  <= t1_last_r;
    t2_err_r   <= t1_err_r;
    prod_r     <= prod_nxt;
    if (t2_v_r) begin
      acc_r <= sum;
    end
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  assign out_valid   = cnt_r != '0;
  assign out_payload = q_r[rd_ptr_r];

endmodule

[src/bilinear_image_resizer.sv]
// Bilinear image resizer: size registers, x and y axis lanes, sampler and fetch unit.
// Throughput: a sample request holds the front pipeline for four reads, set by the frame memory's
//   single read port, and while the result queue is full; a pixel write does not hold it.
// Depends on bir_pkg and the defines header.
// Reset: synchronous, active low; clears control state and sets all sizes to 256.
`include "bilinear_image_resizer_defines.svh"

module bilinear_image_resizer #(
  parameter int MAX_SRC_WIDTH    = 256,
  parameter int MAX_SRC_HEIGHT   = 256,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bir_pkg::in_t                       in_payload,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bir_pkg::out_t                      out_payload,
  input  logic                               cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bir_pkg::*;

  localparam int POS_X_W  = $clog2(MAX_SRC_WIDTH);
  localparam int POS_Y_W  = $clog2(MAX_SRC_HEIGHT);
  localparam int INT_W    = (POS_X_W > POS_Y_W) ? POS_X_W : POS_Y_W;
  localparam int QW       = INT_W + WEIGHT_FRAC_BITS;
  localparam int LANE_LAT = QW + 2;
  localparam int DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SRC_SIZE_LIM = (1 << CFG_SRC_W) - 1;
  localparam int W_CAP = (MAX_SRC_WIDTH > SRC_SIZE_LIM) ? SRC_SIZE_LIM : MAX_SRC_WIDTH;
  localparam int H_CAP = (MAX_SRC_HEIGHT > SRC_SIZE_LIM) ? SRC_SIZE_LIM : MAX_SRC_HEIGHT;

  logic [CFG_SRC_W-1:0] src_width_r;
  logic [CFG_SRC_W-1:0] src_height_r;
  logic [CFG_OUT_W-1:0] out_width_r;
  logic [CFG_OUT_W-1:0] out_height_r;

  logic [CFG_SRC_W-1:0] sw_eff;
  logic [CFG_SRC_W-1:0] sh_eff;
  logic [CFG_OUT_W-1:0] ow_eff;
  logic [CFG_OUT_W-1:0] oh_eff;

  logic  adv;
  logic  accept;
  logic  in_store;
  logic  in_range;
  side_t side_in;
  side_t side_r [LANE_LAT];

  logic [POS_X_W-1:0]          x_lo;
  logic [POS_X_W-1:0]          x_hi;
  logic [WEIGHT_FRAC_BITS-1:0] x_frac;
  logic [POS_Y_W-1:0]          y_lo;
  logic [POS_Y_W-1:0]          y_hi;
  logic [WEIGHT_FRAC_BITS-1:0] y_frac;

  job_ctl_t                          mrg_ctl;
  logic [3:0][ADDR_W-1:0]            mrg_addr;
  logic [3:0][2*WEIGHT_FRAC_BITS:0]  mrg_w;
  logic [PIX_W-1:0]                  mrg_rgb;
  logic                              job_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_SIZE_RST;
      src_height_r <= SRC_SIZE_RST;
      out_width_r  <= OUT_SIZE_RST;
      out_height_r <= OUT_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[CFG_SRC_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata[CFG_SRC_W-1:0];
        REG_OUT_WIDTH:  out_width_r  <= cfg_wdata[CFG_OUT_W-1:0];
        REG_OUT_HEIGHT: out_height_r <= cfg_wdata[CFG_OUT_W-1:0];
      endcase
    end
  end

  // Source sizes are clamped to what the frame memory holds; a zero size counts as one.
  always_comb begin
    if (src_width_r == '0) begin
      sw_eff = CFG_SRC_W'(1);
    end else if (src_width_r > CFG_SRC_W'(W_CAP)) begin
      sw_eff = CFG_SRC_W'(W_CAP);
    end else begin
      sw_eff = src_width_r;
    end
    if (src_height_r == '0) begin
      sh_eff = CFG_SRC_W'(1);
    end else if (src_height_r > CFG_SRC_W'(H_CAP)) begin
      sh_eff = CFG_SRC_W'(H_CAP);
    end else begin
      sh_eff = src_height_r;
    end
    ow_eff = (out_width_r == '0) ? CFG_OUT_W'(1) : out_width_r;
    oh_eff = (out_height_r == '0) ? CFG_OUT_W'(1) : out_height_r;
  end

  // The whole front pipeline moves together; it holds while the fetch unit is busy.
  assign adv      = !mrg_ctl.v || job_done;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  always_comb begin
    in_store = 32'(in_payload.pix_x) < 32'(MAX_SRC_WIDTH)
            && 32'(in_payload.pix_y) < 32'(MAX_SRC_HEIGHT);
    in_range = CFG_OUT_W'(in_payload.pix_x) < ow_eff
            && CFG_OUT_W'(in_payload.pix_y) < oh_eff;
    side_in.x   = in_payload.pix_x;
    side_in.y   = in_payload.pix_y;
    side_in.rgb = {in_payload.chan_red, in_payload.chan_green, in_payload.chan_blue};
    if (in_payload.opcode == OP_WRITE) begin
      // Writes outside the frame memory are dropped here.
      side_in.v    = accept && in_store;
      side_in.kind = KIND_WRITE;
    end else begin
      side_in.v    = accept;
      side_in.kind = in_range ? KIND_SAMPLE : KIND_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        side_r[i].v <= 1'b0;
      end
    end else if (adv) begin
      side_r[0].v <= side_in.v;
      for (int i = 1; i < LANE_LAT; i++) begin
        side_r[i].v <= side_r[i-1].v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].kind <= side_in.kind;
      side_r[0].x    <= side_in.x;
      side_r[0].y    <= side_in.y;
      side_r[0].rgb  <= side_in.rgb;
      for (int i = 1; i < LANE_LAT; i++) begin
        side_r[i].kind <= side_r[i-1].kind;
        side_r[i].x    <= side_r[i-1].x;
        side_r[i].y    <= side_r[i-1].y;
        side_r[i].rgb  <= side_r[i-1].rgb;
      end
    end
  end

  bir_axis_lane #(
    .INT_W  (INT_W),
    .POS_W  (POS_X_W),
    .FRAC_W (WEIGHT_FRAC_BITS)
  ) u_lane_x (
    .clk      (clk),
    .adv      (adv),
    .coord    (in_payload.pix_x),
    .src_size (sw_eff),
    .out_size (ow_eff),
    .pos_lo   (x_lo),
    .pos_hi   (x_hi),
    .pos_frac (x_frac)
  );

  bir_axis_lane #(
    .INT_W  (INT_W),
    .POS_W  (POS_Y_W),
    .FRAC_W (WEIGHT_FRAC_BITS)
  ) u_lane_y (
    .clk      (clk),
    .adv      (adv),
    .coord    (in_payload.pix_y),
    .src_size (sh_eff),
    .out_size (oh_eff),
    .pos_lo   (y_lo),
    .pos_hi   (y_hi),
    .pos_frac (y_frac)
  );

  bir_sampler #(
    .POS_X_W   (POS_X_W),
    .POS_Y_W   (POS_Y_W),
    .FRAC_W    (WEIGHT_FRAC_BITS),
    .ADDR_W    (ADDR_W),
    .ROW_PITCH (MAX_SRC_WIDTH)
  ) u_sampler (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .side     (side_r[LANE_LAT-1]),
    .x_lo     (x_lo),
    .x_hi     (x_hi),
    .x_frac   (x_frac),
    .y_lo     (y_lo),
    .y_hi     (y_hi),
    .y_frac   (y_frac),
    .job_ctl  (mrg_ctl),
    .job_addr (mrg_addr),
    .job_w    (mrg_w),
    .job_rgb  (mrg_rgb)
  );

  bir_fetch #(
    .DEPTH  (DEPTH),
    .FRAC_W (WEIGHT_FRAC_BITS),
    .ADDR_W (ADDR_W)
  ) u_fetch (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_ctl     (mrg_ctl),
    .job_addr    (mrg_addr),
    .job_w       (mrg_w),
    .job_rgb     (mrg_rgb),
    .job_done    (job_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  // A pixel write never holds the pipeline.
  `BIR_ASSERT_IMP(a_write_one_cycle, mrg_ctl.v && mrg_ctl.kind == KIND_WRITE, adv)
  // While the fetch unit works on a transaction, the sampler keeps it unchanged.
  `BIR_ASSERT_NXT(a_job_held, mrg_ctl.v && !adv, mrg_ctl.v && $stable(mrg_addr) && $stable(mrg_w))
  // An out-of-range request carries zero in every channel.
  `BIR_ASSERT_IMP(a_range_zero, out_valid && out_payload.status == STATUS_RANGE, out_payload.out_blue == '0 && out_payload.out_green == '0 && out_payload.out_red == '0)

endmodule

[test/bilinear_image_resizer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_image_resizer: writes source pixels, requests resampled
// pixels under several size settings and compares each result with a local bilinear predictor.
// Depends on bir_pkg and the block's RTL.
module bilinear_image_resizer_tb;
  import bir_pkg::*;

  localparam int MAX_SRC_W    = 256;
  localparam int MAX_SRC_H    = 256;
  localparam int WFRAC        = 8;
  localparam int STORE_DEPTH  = MAX_SRC_W * MAX_SRC_H;
  localparam int MAX_COORD    = (1 << COORD_W) - 1;
  localparam int MAX_OUT_SIZE = 1024;
  localparam int DRAIN_CYCLES = 48;
  localparam int PHASE_ITEMS  = 190;
  localparam int NUM_PHASES   = 8;
  localparam int REPORT_LIMIT = 10;

  typedef longint unsigned u64_t;

  typedef struct packed {
    int lo;
    int hi;
    int frac;
  } axis_tap_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  in_t                   in_payload = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  out_t                  out_payload;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Local copy of the frame memory and the size registers.
  logic [PIX_W-1:0]     src_frame [STORE_DEPTH];
  bit                   pix_written [STORE_DEPTH];
  logic [CFG_SRC_W-1:0] src_w_reg = SRC_SIZE_RST;
  logic [CFG_SRC_W-1:0] src_h_reg = SRC_SIZE_RST;
  logic [CFG_OUT_W-1:0] out_w_reg = OUT_SIZE_RST;
  logic [CFG_OUT_W-1:0] out_h_reg = OUT_SIZE_RST;

  out_t pending_px [$];

  int items_sent = 0;
  int n_writes   = 0;
  int n_requests = 0;
  int n_results  = 0;
  int n_settings = 0;
  int n_fail     = 0;
  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;

  always #5 clk = ~clk;

  bilinear_image_resizer #(
    .MAX_SRC_WIDTH   (MAX_SRC_W),
    .MAX_SRC_HEIGHT  (MAX_SRC_H),
    .WEIGHT_FRAC_BITS(WFRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic int src_extent(input int v, input int max_v);
    if (v < 1) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  function automatic int out_extent(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int pix_addr(input int x, input int y);
    return y * MAX_SRC_W + x;
  endfunction

  // Source position ((2o+1)*S - O) / (2O), clamped, with the fraction cut to WFRAC bits.
  function automatic axis_tap_t map_axis_tap(input int o, input int s, input int n);
    axis_tap_t t;
    longint    num;
    longint    den;
    longint    q;
    longint    r;
    num = longint'(2 * o + 1) * longint'(s) - longint'(n);
    den = 2 * longint'(n);
    t.lo = 0;
    t.frac = 0;
    if (num > 0) begin
      q = num / den;
      r = num % den;
      if (q >= longint'(s - 1)) begin
        t.lo = s - 1;
      end else begin
        t.lo = int'(q);
        t.frac = int'((r << WFRAC) / den);
      end
    end
    t.hi = (t.lo + 1 < s) ? t.lo + 1 : s - 1;
    return t;
  endfunction

  function automatic axis_tap_t x_tap(input int x);
    return map_axis_tap(x, src_extent(int'(src_w_reg), MAX_SRC_W), out_extent(int'(out_w_reg)));
  endfunction

  function automatic axis_tap_t y_tap(input int y);
    return map_axis_tap(y, src_extent(int'(src_h_reg), MAX_SRC_H), out_extent(int'(out_h_reg)));
  endfunction

  // Applies one transaction to the local state; returns 1 when it produces a result.
  function automatic bit resample_pixel(input in_t it, output out_t res);
    int               px;
    int               py;
    axis_tap_t        tx;
    axis_tap_t        ty;
    u64_t             one;
    u64_t             w00;
    u64_t             w01;
    u64_t             w10;
    u64_t             w11;
    u64_t             acc;
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p11;
    logic [RES_W-1:0] chan [3];
    res = '0;
    px = int'(it.pix_x);
    py = int'(it.pix_y);
    if (it.opcode == OP_WRITE) begin
      if (px < MAX_SRC_W && py < MAX_SRC_H) begin
        src_frame[pix_addr(px, py)] = {it.chan_red, it.chan_green, it.chan_blue};
        pix_written[pix_addr(px, py)] = 1'b1;
      end
      return 1'b0;
    end
    if (px >= out_extent(int'(out_w_reg)) || py >= out_extent(int'(out_h_reg))) begin
      res.status = STATUS_RANGE;
      return 1'b1;
    end
    tx = x_tap(px);
    ty = y_tap(py);
    one = u64_t'(1) << WFRAC;
    w00 = (one - u64_t'(ty.frac)) * (one - u64_t'(tx.frac));
    w01 = (one - u64_t'(ty.frac)) * u64_t'(tx.frac);
    w10 = u64_t'(ty.frac) * (one - u64_t'(tx.frac));
    w11 = u64_t'(ty.frac) * u64_t'(tx.frac);
    p00 = src_frame[pix_addr(tx.lo, ty.lo)];
    p01 = src_frame[pix_addr(tx.hi, ty.lo)];
    p10 = src_frame[pix_addr(tx.lo, ty.hi)];
    p11 = src_frame[pix_addr(tx.hi, ty.hi)];
    for (int c = 0; c < 3; c++) begin
      acc = w00 * u64_t'(p00[8*c +: 8]) + w01 * u64_t'(p01[8*c +: 8])
          + w10 * u64_t'(p10[8*c +: 8]) + w11 * u64_t'(p11[8*c +: 8]);
      if (2 * WFRAC >= 16) begin
        acc = acc >> (2 * WFRAC - 16);
      end else begin
        acc = acc << (16 - 2 * WFRAC);
      end
      chan[c] = RES_W'(acc);
    end
    res.out_blue  = chan[0];
    res.out_green = chan[1];
    res.out_red   = chan[2];
    res.status    = STATUS_OK;
    return 1'b1;
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CHAN_W'($urandom);
  endfunction

  function automatic logic [PIX_W-1:0] random_bgr();
    return {pick_chan(), pick_chan(), pick_chan()};
  endfunction

  function automatic int random_src_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(MAX_SRC_W + 1, (1 << CFG_SRC_W) - 1);
      2: return MAX_SRC_W;
      3: return 1;
      default: return $urandom_range(1, MAX_SRC_W);
    endcase
  endfunction

  function automatic int random_out_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(MAX_OUT_SIZE + 1, (1 << CFG_OUT_W) - 1);
      2: return MAX_OUT_SIZE;
      3: return 1;
      default: return $urandom_range(1, MAX_OUT_SIZE);
    endcase
  endfunction

  task automatic report_failure(input string msg);
    n_fail++;
    if (n_fail <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Sends one transaction and records what it should produce once it is accepted.
  task automatic push_item(input in_t it);
    int   gap;
    out_t res;
    if ($urandom_range(0, 63) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (resample_pixel(it, res)) begin
      pending_px = {pending_px, res};
      n_requests++;
    end
    items_sent++;
  endtask

  task automatic write_pixel(input int x, input int y, input logic [PIX_W-1:0] bgr);
    in_t it;
    it = '0;
    it.opcode     = OP_WRITE;
    it.pix_x      = COORD_W'(x);
    it.pix_y      = COORD_W'(y);
    it.chan_blue  = bgr[7:0];
    it.chan_green = bgr[15:8];
    it.chan_red   = bgr[23:16];
    n_writes++;
    push_item(it);
  endtask

  task automatic request_pixel(input int x, input int y);
    in_t it;
    it = '0;
    it.opcode     = OP_SAMPLE;
    it.pix_x      = COORD_W'(x);
    it.pix_y      = COORD_W'(y);
    it.chan_blue  = CHAN_W'($urandom);
    it.chan_green = CHAN_W'($urandom);
    it.chan_red   = CHAN_W'($urandom);
    push_item(it);
  endtask

  // Writes whichever of the four neighbours is still empty (or, with refresh, some at random)
  // so that the request never reads an unwritten memory entry.
  task automatic sample_primed(input int x, input int y, input bit refresh);
    axis_tap_t tx;
    axis_tap_t ty;
    int        nx [4];
    int        ny [4];
    tx = x_tap(x);
    ty = y_tap(y);
    nx = '{tx.lo, tx.hi, tx.lo, tx.hi};
    ny = '{ty.lo, ty.lo, ty.hi, ty.hi};
    for (int k = 0; k < 4; k++) begin
      if (!pix_written[pix_addr(nx[k], ny[k])] || (refresh && $urandom_range(0, 3) == 0))
        write_pixel(nx[k], ny[k], random_bgr());
    end
    request_pixel(x, y);
  endtask

  // Lets every outstanding request finish before the sizes may change.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:  src_w_reg = CFG_SRC_W'(val);
      REG_SRC_HEIGHT: src_h_reg = CFG_SRC_W'(val);
      REG_OUT_WIDTH:  out_w_reg = CFG_OUT_W'(val);
      REG_OUT_HEIGHT: out_h_reg = CFG_OUT_W'(val);
      default: ;
    endcase
  endtask

  task automatic program_sizes(input int sw, input int sh, input int ow, input int oh);
    settle();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_item();
    int ow;
    int oh;
    int x;
    int y;
    int r;
    ow = out_extent(int'(out_w_reg));
    oh = out_extent(int'(out_h_reg));
    r = $urandom_range(0, 99);
    if (r >= 88 && ow <= MAX_COORD && (oh > MAX_COORD || $urandom_range(0, 1) == 0)) begin
      request_pixel($urandom_range(ow, MAX_COORD), $urandom_range(0, MAX_COORD));
    end else if (r >= 88 && oh <= MAX_COORD) begin
      request_pixel($urandom_range(0, MAX_COORD), $urandom_range(oh, MAX_COORD));
    end else if (r >= 80 && r < 88) begin
      // Writes past the store edge are dropped by the block.
      x = $urandom_range(0, MAX_COORD);
      y = $urandom_range(MAX_SRC_H, MAX_COORD);
      if ($urandom_range(0, 1) == 1) write_pixel(y, x, random_bgr());
      else write_pixel(x, y, random_bgr());
    end else if (r >= 65 && r < 80) begin
      write_pixel($urandom_range(0, MAX_SRC_W - 1), $urandom_range(0, MAX_SRC_H - 1),
                  random_bgr());
    end else begin
      x = $urandom_range(0, ((ow > MAX_COORD) ? MAX_COORD + 1 : ow) - 1);
      y = $urandom_range(0, ((oh > MAX_COORD) ? MAX_COORD + 1 : oh) - 1);
      sample_primed(x, y, 1'b1);
    end
  endtask

  // Reset sizes give an identity mapping: corners, edges and requests out of range.
  task automatic test_reset_sizes();
    write_pixel(0, 0, 24'hFFFFFF);
    write_pixel(1, 0, 24'h000000);
    write_pixel(0, 1, 24'hFF00FF);
    write_pixel(1, 1, 24'h00FF00);
    // These land outside the store and must not alias onto the pixels above.
    write_pixel(MAX_SRC_W, 0, 24'h5A5A5A);
    write_pixel(MAX_COORD, MAX_COORD, 24'hA5A5A5);
    sample_primed(0, 0, 1'b0);
    sample_primed(1, 0, 1'b0);
    write_pixel(MAX_SRC_W - 1, MAX_SRC_H - 1, 24'hFFFFFF);
    sample_primed(MAX_SRC_W - 1, MAX_SRC_H - 1, 1'b0);
    request_pixel(int'(out_w_reg), 0);
    request_pixel(MAX_COORD, MAX_COORD);
  endtask

  // A 2x2 source stretched to a 1024x1024 output exercises fractional weights.
  task automatic test_upscale();
    program_sizes(2, 2, MAX_OUT_SIZE, MAX_OUT_SIZE);
    write_pixel(0, 0, 24'hFFFFFF);
    write_pixel(1, 0, 24'h000000);
    write_pixel(0, 1, 24'h000000);
    write_pixel(1, 1, 24'hFFFFFF);
    sample_primed(0, 0, 1'b0);
    sample_primed(MAX_COORD, MAX_COORD, 1'b0);
    sample_primed(511, 511, 1'b0);
    sample_primed(300, 700, 1'b0);
  endtask

  // Zero register values count as one and oversized source sizes are clamped by the block.
  task automatic test_size_clamps();
    program_sizes(0, (1 << CFG_SRC_W) - 1, (1 << CFG_OUT_W) - 1, 0);
    sample_primed(MAX_COORD, 0, 1'b1);
    request_pixel(5, 1);
    program_sizes(MAX_SRC_W + 1, 1, 1, MAX_OUT_SIZE + 1);
    sample_primed(0, MAX_COORD, 1'b1);
    request_pixel(1, 0);
  endtask

  task automatic test_random_sizes();
    int start;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_sizes(1, 1, 1, 1);
        1: program_sizes(MAX_SRC_W, MAX_SRC_H, MAX_OUT_SIZE, MAX_OUT_SIZE);
        2: program_sizes(MAX_SRC_W, 1, 1, MAX_OUT_SIZE);
        3: program_sizes(3, MAX_SRC_H, 7, 2);
        default: program_sizes(random_src_size(), random_src_size(), random_out_size(),
                               random_out_size());
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) random_item();
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    n_results++;
    if (pending_px.size() == 0) begin
      report_failure($sformatf("result without an outstanding request: b=%h g=%h r=%h st=%b",
                               got.out_blue, got.out_green, got.out_red, got.status));
      return;
    end
    want = pending_px.pop_front();
    if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
        got.out_red !== want.out_red || got.status !== want.status) begin
      report_failure($sformatf("result %0d: expected b=%h g=%h r=%h st=%b, got b=%h g=%h r=%h st=%b",
                               n_results, want.out_blue, want.out_green, want.out_red,
                               want.status, got.out_blue, got.out_green, got.out_red,
                               got.status));
    end
  endtask

  // Result side: random back-pressure, each accepted transaction checked in order.
  initial begin : result_monitor
    int   stall;
    out_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      got = out_payload;
      @(posedge clk);
      check_result(got);
    end
  end

  initial begin : main_sequence
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_sizes();
    test_upscale();
    test_size_clamps();
    test_random_sizes();
    settle();
    if (pending_px.size() != 0) report_failure("requests left without a result");
    $display("Checked %0d resampled pixels from %0d requests against %0d source writes.",
             n_results, n_requests, n_writes);
    $display("Covered %0d size settings; failures seen: %0d", n_settings, n_fail);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d results still outstanding", pending_px.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
